### rtl/core/ocd_pkg.sv
// Shared types and constants for the occupancy current detector.
// No dependencies; every other file refers to it by scoped names.
package ocd_pkg;

    // Field widths
    localparam int unsigned SAMPLE_W    = 10;
    localparam int unsigned PIN_W       = 2;
    localparam int unsigned SUM_W       = 16;
    localparam int unsigned THR_W       = 10;
    localparam int unsigned DELAY_W     = 8;
    localparam int unsigned CAL_SUM_W   = 14;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 10;

    // Pin positions within the raw pin word
    localparam int unsigned PIN_AUX    = 0;
    localparam int unsigned PIN_BUTTON = 1;

    // Register defaults and erased-value handling
    localparam logic [THR_W-1:0]   DEFAULT_THRESHOLD = 10'h01D;
    localparam logic [DELAY_W-1:0] DEFAULT_ON_DELAY  = 8'd4;
    localparam logic [DELAY_W-1:0] DEFAULT_OFF_DELAY = 8'd25;
    localparam logic [DELAY_W-1:0] ERASED_DELAY      = 8'hFF;

    // Hysteresis offset and the limits within which it is applied
    localparam logic [THR_W-1:0] HYST     = 10'd5;
    localparam logic [THR_W-1:0] HYST_TOP = 10'd1018;

    // Calibration rule
    localparam logic [CAL_SUM_W-1:0] CAL_MARGIN   = 14'd8;
    localparam logic [CAL_SUM_W-1:0] CAL_MIN_MEAN = 14'd9;
    localparam int unsigned          NINETY_NUM   = 9;
    localparam int unsigned          NINETY_DEN   = 10;

    // Depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_START_THRESHOLD = 2'd0,
        REG_ON_DELAY        = 2'd1,
        REG_OFF_DELAY       = 2'd2
    } t_reg_index;

    // One completed average with the pin reads that came with it
    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic [PIN_W-1:0]    pins;
    } t_avg_word;

    // One result word
    typedef struct packed {
        logic                occupied;
        logic                detected;
        logic                calibrating;
        logic [THR_W-1:0]    threshold;
        logic [SAMPLE_W-1:0] average;
    } t_result;

    // Configuration write
    typedef struct packed {
        logic                   we;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } t_cfg_wr;

endpackage

### rtl/core/ocd_front.sv
// Front part: accepts sample words, sums each group and turns the sum into
// an average by reciprocal multiplication. Depends on ocd_pkg.
module ocd_front #(
    parameter int SAMPLES_PER_AVERAGE = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ocd_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [ocd_pkg::PIN_W-1:0]     i_raw_inputs,
    input  logic                          i_space,
    output logic                          o_push,
    output ocd_pkg::t_avg_word            o_word
);

    localparam int CNT_W     = $clog2(SAMPLES_PER_AVERAGE);
    // Exact floor division of a SUM_W-bit value by the group size
    localparam int DIV_SHIFT = ocd_pkg::SUM_W + $clog2(SAMPLES_PER_AVERAGE);
    localparam int DIV_MULT  = (2**DIV_SHIFT + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;
    localparam int PROD_W    = DIV_SHIFT + ocd_pkg::SUM_W;

    logic [ocd_pkg::SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic [ocd_pkg::SUM_W-1:0] r_done_sum, n_done_sum;
    logic [ocd_pkg::PIN_W-1:0] r_done_pins, n_done_pins;
    logic                      r_done_vld, n_done_vld;
    logic                      accept;
    logic                      last;
    logic [ocd_pkg::SUM_W-1:0] sum_add;
    logic [PROD_W-1:0]         prod;

    // Take a word unless the finished sum is stuck behind a full queue
    assign o_ready = !r_done_vld || i_space;
    assign accept  = i_valid && o_ready;
    assign o_push  = r_done_vld && i_space;
    assign sum_add = r_sum + ocd_pkg::SUM_W'(i_sample);
    assign last    = (r_cnt == CNT_W'(SAMPLES_PER_AVERAGE - 1));

    // Advance the group sum and close the group on its last sample
    always_comb begin
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_done_sum  = r_done_sum;
        n_done_pins = r_done_pins;
        n_done_vld  = r_done_vld && !o_push;
        if (accept) begin
            if (last) begin
                n_sum       = '0;
                n_cnt       = '0;
                n_done_sum  = sum_add;
                n_done_pins = i_raw_inputs;
                n_done_vld  = 1'b1;
            end else begin
                n_sum = sum_add;
                n_cnt = r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_cnt      <= '0;
            r_done_vld <= 1'b0;
        end else begin
            r_sum      <= n_sum;
            r_cnt      <= n_cnt;
            r_done_vld <= n_done_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_done_sum  <= n_done_sum;
        r_done_pins <= n_done_pins;
    end

    // Divide the held sum; the queue entry registers the product
    assign prod           = PROD_W'(r_done_sum) * PROD_W'(DIV_MULT);
    assign o_word.average = prod[DIV_SHIFT +: ocd_pkg::SAMPLE_W];
    assign o_word.pins    = r_done_pins;

endmodule

### rtl/core/ocd_queue.sv
// Short queue of average words between front and back.
// Depends on ocd_pkg for the word type and depth.
module ocd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ocd_pkg::t_avg_word i_word,
    output logic               o_space,
    input  logic               i_pop,
    output logic               o_vld,
    output ocd_pkg::t_avg_word o_word
);

    localparam int PTR_W = $clog2(ocd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ocd_pkg::QUEUE_DEPTH + 1);

    ocd_pkg::t_avg_word r_mem [ocd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_space = (r_count != CNT_W'(ocd_pkg::QUEUE_DEPTH));
    assign o_vld   = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];

    // Track occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

endmodule

### rtl/core/ocd_back.sv
// Back part: debounce, button and calibration handling, threshold detector
// and the output register. Depends on ocd_pkg.
module ocd_back #(
    parameter int CAL_READS         = 16,
    parameter int BUTTON_HOLD_READS = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ocd_pkg::t_cfg_wr   i_cfg,
    input  logic               i_vld,
    input  ocd_pkg::t_avg_word i_word,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ocd_pkg::t_result   o_result
);

    localparam int HOLD_W = $clog2(BUTTON_HOLD_READS + 1);
    localparam int REM_W  = $clog2(CAL_READS + 1);
    localparam int CSW    = ocd_pkg::CAL_SUM_W;
    // Exact floor division of the calibration sum by CAL_READS
    localparam int MEAN_SHIFT  = CSW + $clog2(CAL_READS);
    localparam int MEAN_MULT   = (2**MEAN_SHIFT + CAL_READS - 1) / CAL_READS;
    localparam int MEAN_PROD_W = MEAN_SHIFT + CSW;
    // Exact floor of (9 * sum) / (10 * CAL_READS); 9 * sum fits in CSW + 4 bits
    localparam int NINETY_DIV    = ocd_pkg::NINETY_DEN * CAL_READS;
    localparam int NINETY_SHIFT  = CSW + 4 + $clog2(NINETY_DIV);
    localparam int NINETY_MULT   = ((2**NINETY_SHIFT + NINETY_DIV - 1) / NINETY_DIV)
                                   * ocd_pkg::NINETY_NUM;
    localparam int NINETY_PROD_W = NINETY_SHIFT + CSW;

    localparam int THW = ocd_pkg::THR_W;
    localparam int DW  = ocd_pkg::DELAY_W;

    logic [THW-1:0]              r_thr, n_thr;
    logic [DW-1:0]               r_on_delay, n_on_delay;
    logic [DW-1:0]               r_off_delay, n_off_delay;
    logic                        r_det, n_det;
    logic [DW-1:0]               r_on_cnt, n_on_cnt;
    logic [DW-1:0]               r_off_cnt, n_off_cnt;
    logic [ocd_pkg::PIN_W-1:0]   r_deb, n_deb;
    logic [ocd_pkg::PIN_W-1:0]   r_vl, n_vl;
    logic [ocd_pkg::PIN_W-1:0]   r_vh, n_vh;
    logic [HOLD_W-1:0]           r_hold, n_hold;
    logic                        r_cal_mode, n_cal_mode;
    logic [REM_W-1:0]            r_cal_rem, n_cal_rem;
    logic [CSW-1:0]              r_cal_sum, n_cal_sum;
    logic [CSW-1:0]              r_mean, r_ninety;
    logic                        r_calc_busy, n_calc_busy;
    logic                        r_out_vld;
    ocd_pkg::t_result            r_out, n_out;

    logic [ocd_pkg::PIN_W-1:0]   delta;
    logic [THW-1:0]              hyst_thr;
    logic [CSW-1:0]              cal_thr;
    logic [CSW-1:0]              mean_gap;
    logic [MEAN_PROD_W-1:0]      mean_prod;
    logic [NINETY_PROD_W-1:0]    ninety_prod;
    logic                        occ;
    logic [DW-1:0]               cfg_delay;

    // Take a word when the output register is free and the mean is current
    assign o_pop = i_vld && (!r_out_vld || i_out_ready) && !r_calc_busy;

    // Refresh mean and ninety value from the calibration sum every cycle
    assign mean_prod   = MEAN_PROD_W'(r_cal_sum) * MEAN_PROD_W'(MEAN_MULT);
    assign ninety_prod = NINETY_PROD_W'(r_cal_sum) * NINETY_PROD_W'(NINETY_MULT);

    always_ff @(posedge i_clk) begin
        r_mean   <= mean_prod[MEAN_SHIFT +: CSW];
        r_ninety <= ninety_prod[NINETY_SHIFT +: CSW];
    end

    // Pick the calibrated threshold
    assign mean_gap = r_mean - r_ninety;
    always_comb begin
        if (mean_gap < ocd_pkg::CAL_MARGIN && r_mean >= ocd_pkg::CAL_MIN_MEAN) begin
            cal_thr = r_mean - ocd_pkg::CAL_MARGIN;
        end else begin
            cal_thr = r_ninety;
        end
    end

    // Hysteresis: lower while detected, raise while clear
    always_comb begin
        hyst_thr = r_thr;
        if (r_det && r_thr >= ocd_pkg::HYST) begin
            hyst_thr = r_thr - ocd_pkg::HYST;
        end else if (!r_det && r_thr <= ocd_pkg::HYST_TOP) begin
            hyst_thr = r_thr + ocd_pkg::HYST;
        end
    end

    assign delta     = i_word.pins ^ r_deb;
    assign cfg_delay = i_cfg.data[DW-1:0];

    // Next state for configuration writes and each popped average
    always_comb begin
        n_thr       = r_thr;
        n_on_delay  = r_on_delay;
        n_off_delay = r_off_delay;
        n_det       = r_det;
        n_on_cnt    = r_on_cnt;
        n_off_cnt   = r_off_cnt;
        n_deb       = r_deb;
        n_vl        = r_vl;
        n_vh        = r_vh;
        n_hold      = r_hold;
        n_cal_mode  = r_cal_mode;
        n_cal_rem   = r_cal_rem;
        n_cal_sum   = r_cal_sum;
        n_calc_busy = 1'b0;
        occ         = 1'b0;

        if (i_cfg.we) begin
            unique case (i_cfg.index)
                ocd_pkg::REG_START_THRESHOLD: begin
                    n_thr = (i_cfg.data[THW-1:0] == '0) ? ocd_pkg::DEFAULT_THRESHOLD
                                                        : i_cfg.data[THW-1:0];
                end
                ocd_pkg::REG_ON_DELAY: begin
                    n_on_delay = (cfg_delay == '0 || cfg_delay == ocd_pkg::ERASED_DELAY)
                               ? ocd_pkg::DEFAULT_ON_DELAY : cfg_delay;
                end
                ocd_pkg::REG_OFF_DELAY: begin
                    n_off_delay = (cfg_delay == '0 || cfg_delay == ocd_pkg::ERASED_DELAY)
                                ? ocd_pkg::DEFAULT_OFF_DELAY : cfg_delay;
                end
                default: ;
            endcase
        end

        if (o_pop) begin
            if (r_cal_mode) begin
                // Collect averages, then finish with the new threshold
                if (r_cal_rem != '0) begin
                    n_cal_rem   = r_cal_rem - REM_W'(1);
                    n_cal_sum   = r_cal_sum + CSW'(i_word.average);
                    n_calc_busy = 1'b1;
                end else begin
                    n_thr      = cal_thr[THW-1:0];
                    n_cal_mode = 1'b0;
                end
            end else begin
                // Vertical counter debounce
                n_vh  = (r_vh ^ r_vl) & delta;
                n_vl  = ~r_vl & delta;
                n_deb = r_deb ^ (delta & ~n_vh & ~n_vl);

                // Button hold and release
                if (n_deb[ocd_pkg::PIN_BUTTON]) begin
                    if (r_hold != '0) begin
                        n_hold = r_hold - HOLD_W'(1);
                    end
                end else begin
                    if (r_hold == '0) begin
                        n_cal_mode  = 1'b1;
                        n_cal_sum   = '0;
                        n_calc_busy = 1'b1;
                    end
                    n_hold    = HOLD_W'(BUTTON_HOLD_READS);
                    n_cal_rem = REM_W'(CAL_READS);
                end

                // Detector with on and off delays
                if (i_word.average > hyst_thr) begin
                    if (!r_det) begin
                        if (r_on_cnt < r_on_delay) begin
                            n_on_cnt = r_on_cnt + DW'(1);
                        end else begin
                            n_det     = 1'b1;
                            n_off_cnt = '0;
                        end
                    end else begin
                        n_off_cnt = '0;
                    end
                end else begin
                    if (r_det) begin
                        if (r_off_cnt < r_off_delay) begin
                            n_off_cnt = r_off_cnt + DW'(1);
                        end else begin
                            n_det    = 1'b0;
                            n_on_cnt = '0;
                        end
                    end else begin
                        n_on_cnt = '0;
                    end
                end
                occ = n_det | n_deb[ocd_pkg::PIN_AUX];
            end
        end
    end

    // Build the result word
    always_comb begin
        n_out.occupied    = occ;
        n_out.detected    = n_det;
        n_out.calibrating = n_cal_mode;
        n_out.threshold   = n_thr;
        n_out.average     = i_word.average;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= ocd_pkg::DEFAULT_THRESHOLD;
            r_on_delay  <= ocd_pkg::DEFAULT_ON_DELAY;
            r_off_delay <= ocd_pkg::DEFAULT_OFF_DELAY;
            r_det       <= 1'b0;
            r_on_cnt    <= '0;
            r_off_cnt   <= '0;
            r_deb       <= '0;
            r_vl        <= '0;
            r_vh        <= '0;
            r_hold      <= HOLD_W'(BUTTON_HOLD_READS);
            r_cal_mode  <= 1'b0;
            r_cal_rem   <= REM_W'(CAL_READS);
            r_cal_sum   <= '0;
            r_calc_busy <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_thr       <= n_thr;
            r_on_delay  <= n_on_delay;
            r_off_delay <= n_off_delay;
            r_det       <= n_det;
            r_on_cnt    <= n_on_cnt;
            r_off_cnt   <= n_off_cnt;
            r_deb       <= n_deb;
            r_vl        <= n_vl;
            r_vh        <= n_vh;
            r_hold      <= n_hold;
            r_cal_mode  <= n_cal_mode;
            r_cal_rem   <= n_cal_rem;
            r_cal_sum   <= n_cal_sum;
            r_calc_busy <= n_calc_busy;
            if (o_pop) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_result    = r_out;

endmodule

### rtl/core/occupancy_current_detector_core.sv
// Top level of the occupancy current detector: front, queue and back.
// Depends on ocd_pkg, ocd_front, ocd_queue and ocd_back.
//
// Input channel (i_in_valid / o_in_ready): one converter sample and the two
// raw pin bits per word; a word is taken every cycle unless a finished sum
// waits behind a full queue. Every SAMPLES_PER_AVERAGE words close one
// average and give exactly one result word on the output channel
// (o_out_valid / i_out_ready); other words give none.
// The result of a group is held in turn by the group sum register, a queue
// entry and the output register.
// Throughput: one sample per cycle while o_in_ready is high. The back part
// handles one average per cycle while the receiver is ready, except that it
// pauses after each calibration sum update while the mean and ninety value
// registers catch up; the two-word queue absorbs the pause.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at
// the next edge; writing start_threshold also replaces the threshold in use.
// Reset (synchronous, active low) clears sums, counters and calibration and
// loads the default registers; no result is pending afterwards.
// When the receiver stalls, the result word holds, the back part stops, the
// queue fills and then o_in_ready drops.
module occupancy_current_detector_core #(
    parameter int SAMPLES_PER_AVERAGE = 64,
    parameter int CAL_READS           = 16,
    parameter int BUTTON_HOLD_READS   = 20
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [ocd_pkg::SAMPLE_W-1:0]     i_sample,
    input  logic [ocd_pkg::PIN_W-1:0]        i_raw_inputs,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_occupied,
    output logic                             o_detected,
    output logic                             o_calibrating,
    output logic [ocd_pkg::THR_W-1:0]        o_threshold,
    output logic [ocd_pkg::SAMPLE_W-1:0]     o_average,
    input  logic                             i_cfg_we,
    input  logic [ocd_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [ocd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic               push;
    logic               q_space;
    logic               q_vld;
    logic               pop;
    ocd_pkg::t_avg_word front_word;
    ocd_pkg::t_avg_word q_word;
    ocd_pkg::t_cfg_wr   cfg;
    ocd_pkg::t_result   result;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    ocd_front #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_sample     (i_sample),
        .i_raw_inputs (i_raw_inputs),
        .i_space      (q_space),
        .o_push       (push),
        .o_word       (front_word)
    );

    ocd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (front_word),
        .o_space (q_space),
        .i_pop   (pop),
        .o_vld   (q_vld),
        .o_word  (q_word)
    );

    ocd_back #(
        .CAL_READS         (CAL_READS),
        .BUTTON_HOLD_READS (BUTTON_HOLD_READS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_vld       (q_vld),
        .i_word      (q_word),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_occupied    = result.occupied;
    assign o_detected    = result.detected;
    assign o_calibrating = result.calibrating;
    assign o_threshold   = result.threshold;
    assign o_average     = result.average;

    // Never push into a full queue
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> q_space)
        else $error("average word pushed into a full queue");

    // Never pop an empty queue
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_vld)
        else $error("average word popped from an empty queue");

    // A new result only follows a pop from the queue
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(pop))
        else $error("result word raised without a popped average");

endmodule

### bench/tb_top.sv
// Self-checking bench for occupancy_current_detector_core: sample averaging,
// pin debouncing, detection with hysteresis and delays, and calibration.
// Depends on ocd_pkg and the core; a local predictor supplies expected words.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD      = 20;
    localparam int          SAMPLES_PER_AVG = 64;
    localparam int unsigned CAL_AVERAGES    = 16;
    localparam int unsigned HOLD_AVERAGES   = 20;
    localparam int unsigned CAL_MARGIN_T    = 8;
    localparam int unsigned CAL_FLOOR_T     = 9;
    localparam logic [9:0]  THR_DEFAULT     = 10'd29;
    localparam logic [7:0]  ON_DEFAULT      = 8'd4;
    localparam logic [7:0]  OFF_DEFAULT     = 8'd25;
    localparam logic [7:0]  DELAY_ERASED    = 8'hFF;
    localparam logic [9:0]  HYST_STEP       = 10'd5;
    localparam logic [9:0]  HYST_CEIL       = 10'd1018;
    localparam logic [ocd_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int          RANDOM_GROUPS   = 110;
    localparam int          DRAIN_CYCLES    = 8;
    localparam int unsigned CYCLE_LIMIT     = 1_000_000;

    typedef enum {ROW_GROUP, ROW_WRITE} t_row_kind;
    typedef enum {SCN_CALIBRATE, SCN_DETECT, SCN_NOISE} t_scenario;

    // One line of the directed plan: a whole averaging group or a register write
    typedef struct {
        t_row_kind                       kind;
        int                              level;
        int                              spread;
        logic [1:0]                      pins;
        bit                              lit_on;
        ocd_pkg::t_result                lit;
        logic [ocd_pkg::CFG_INDEX_W-1:0] reg_idx;
        logic [ocd_pkg::CFG_DATA_W-1:0]  reg_data;
    } t_plan_row;

    // Block inputs, all known from time zero
    logic                            i_clk        = 1'b0;
    logic                            i_rst_n      = 1'b0;
    logic                            i_in_valid   = 1'b0;
    logic [ocd_pkg::SAMPLE_W-1:0]    i_sample     = '0;
    logic [ocd_pkg::PIN_W-1:0]       i_raw_inputs = '0;
    logic                            i_out_ready  = 1'b0;
    logic                            i_cfg_we     = 1'b0;
    logic [ocd_pkg::CFG_INDEX_W-1:0] i_cfg_index  = '0;
    logic [ocd_pkg::CFG_DATA_W-1:0]  i_cfg_data   = '0;

    logic                            o_in_ready;
    logic                            o_out_valid;
    logic                            o_occupied;
    logic                            o_detected;
    logic                            o_calibrating;
    logic [ocd_pkg::THR_W-1:0]       o_threshold;
    logic [ocd_pkg::SAMPLE_W-1:0]    o_average;

    // Typed expectation travelling with the word that closes a directed group
    bit               word_lit_on = 1'b0;
    ocd_pkg::t_result word_lit    = '0;

    // Predictor state, starting at its reset values
    logic [15:0] sum_acc   = '0;
    int          count_acc = 0;
    logic [9:0]  avg_last  = '0;
    logic [9:0]  thr_now   = THR_DEFAULT;
    logic [7:0]  on_dly    = ON_DEFAULT;
    logic [7:0]  off_dly   = OFF_DEFAULT;
    logic        det_on    = 1'b0;
    logic [7:0]  on_cnt    = '0;
    logic [7:0]  off_cnt   = '0;
    logic [1:0]  pins_deb  = '0;
    logic [1:0]  vlow      = '0;
    logic [1:0]  vhigh     = '0;
    logic [4:0]  hold_left = 5'(HOLD_AVERAGES);
    logic        cal_on    = 1'b0;
    logic [4:0]  cal_left  = 5'(CAL_AVERAGES);
    logic [13:0] cal_acc   = '0;

    ocd_pkg::t_result pending_status[$];
    t_plan_row        plan[$];
    ocd_pkg::t_result want;
    int               fault_count = 0;
    int               burst_left  = 0;
    int               groups_sent = 0;
    int unsigned      rx_left     = 0;
    int unsigned      cycle_count = 0;

    occupancy_current_detector_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_sample      (i_sample),
        .i_raw_inputs  (i_raw_inputs),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_occupied    (o_occupied),
        .o_detected    (o_detected),
        .o_calibrating (o_calibrating),
        .o_threshold   (o_threshold),
        .o_average     (o_average),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Mirror a register write, erased values falling back to the defaults
    task automatic apply_reg_write(input logic [ocd_pkg::CFG_INDEX_W-1:0] idx,
                                   input logic [ocd_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            ocd_pkg::REG_START_THRESHOLD: begin
                thr_now = (data == '0) ? THR_DEFAULT : data;
            end
            ocd_pkg::REG_ON_DELAY: begin
                on_dly = (data[7:0] == '0 || data[7:0] == DELAY_ERASED) ? ON_DEFAULT : data[7:0];
            end
            ocd_pkg::REG_OFF_DELAY: begin
                off_dly = (data[7:0] == '0 || data[7:0] == DELAY_ERASED) ? OFF_DEFAULT : data[7:0];
            end
            default: ;
        endcase
    endtask

    // Fold one accepted word into the running average; a closed group yields a status word
    task automatic fold_sample(input logic [9:0] s, input logic [1:0] pins,
                               input bit lit_on, input ocd_pkg::t_result lit);
        logic [1:0]       delta;
        logic [9:0]       edge_thr;
        logic             occ;
        int unsigned      mean;
        int unsigned      ninety;
        ocd_pkg::t_result got;
        sum_acc = sum_acc + 16'(s);
        if (count_acc + 1 < SAMPLES_PER_AVG) begin
            count_acc = count_acc + 1;
        end else begin
            avg_last  = 10'(sum_acc / SAMPLES_PER_AVG);
            sum_acc   = '0;
            count_acc = 0;
            occ       = 1'b0;
            if (cal_on) begin
                // Collect averages, then settle the new threshold on the next one
                if (cal_left != 0) begin
                    cal_left = cal_left - 1'b1;
                    cal_acc  = cal_acc + 14'(avg_last);
                end else begin
                    mean   = cal_acc / CAL_AVERAGES;
                    ninety = (9 * cal_acc) / (10 * CAL_AVERAGES);
                    if (mean - ninety < CAL_MARGIN_T && mean >= CAL_FLOOR_T)
                        thr_now = 10'(mean - CAL_MARGIN_T);
                    else
                        thr_now = 10'(ninety);
                    cal_on = 1'b0;
                end
            end else begin
                // Vertical counters: a pin flips after four differing reads
                delta    = pins ^ pins_deb;
                vhigh    = (vhigh ^ vlow) & delta;
                vlow     = ~vlow & delta;
                pins_deb = pins_deb ^ (delta & ~vhigh & ~vlow);

                // Button hold and release into calibration
                if (pins_deb[ocd_pkg::PIN_BUTTON]) begin
                    if (hold_left != 0)
                        hold_left = hold_left - 1'b1;
                end else begin
                    if (hold_left == 0) begin
                        cal_on  = 1'b1;
                        cal_acc = '0;
                    end
                    hold_left = 5'(HOLD_AVERAGES);
                    cal_left  = 5'(CAL_AVERAGES);
                end

                // Threshold shifted by hysteresis, then on and off delays
                edge_thr = thr_now;
                if (det_on && thr_now >= HYST_STEP)
                    edge_thr = thr_now - HYST_STEP;
                else if (!det_on && thr_now <= HYST_CEIL)
                    edge_thr = thr_now + HYST_STEP;

                if (avg_last > edge_thr) begin
                    if (!det_on) begin
                        if (on_cnt < on_dly) begin
                            on_cnt = on_cnt + 1'b1;
                        end else begin
                            det_on  = 1'b1;
                            off_cnt = '0;
                        end
                    end else begin
                        off_cnt = '0;
                    end
                end else begin
                    if (det_on) begin
                        if (off_cnt < off_dly) begin
                            off_cnt = off_cnt + 1'b1;
                        end else begin
                            det_on = 1'b0;
                            on_cnt = '0;
                        end
                    end else begin
                        on_cnt = '0;
                    end
                end
                occ = det_on | pins_deb[ocd_pkg::PIN_AUX];
            end
            got = '{occupied: occ, detected: det_on, calibrating: cal_on,
                    threshold: thr_now, average: avg_last};
            pending_status.push_back(lit_on ? lit : got);
        end
    endtask

    // Track writes and accepted words
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                apply_reg_write(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready)
                fold_sample(i_sample, i_raw_inputs, word_lit_on, word_lit);
        end
    end

    task automatic compare_field(input string label, input int unsigned exp_v,
                                 input int unsigned act_v);
        if (exp_v != act_v) begin
            fault_count++;
            $display("%0t ns: %s expected %0d, got %0d", $time, label, exp_v, act_v);
        end
    endtask

    // Check each delivered status word against the oldest one awaited
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_status.size() == 0) begin
                fault_count++;
                $display("%0t ns: status word with none awaited, expected nothing, got average %0d",
                         $time, o_average);
            end else begin
                want = pending_status.pop_front();
                compare_field("occupied", want.occupied, o_occupied);
                compare_field("detected", want.detected, o_detected);
                compare_field("calibrating", want.calibrating, o_calibrating);
                compare_field("threshold", want.threshold, o_threshold);
                compare_field("average", want.average, o_average);
            end
        end
    end

    // Receiver: ready runs broken by short, medium and long stalls
    always @(posedge i_clk) begin
        if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else if (i_out_ready) begin
            i_out_ready <= 1'b0;
            case ($urandom_range(0, 9))
                0:       rx_left <= $urandom_range(150, 400);
                1, 2:    rx_left <= $urandom_range(20, 80);
                default: rx_left <= $urandom_range(0, 4);
            endcase
        end else begin
            i_out_ready <= 1'b1;
            rx_left     <= $urandom_range(1, 300);
        end
    end

    // Give up after a generous number of cycles
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [9:0] to_sample(input int v);
        if (v < 0)
            return '0;
        if (v > 1023)
            return 10'd1023;
        return 10'(v);
    endfunction

    // Offer one word, holding it until taken; words go in bursts with idle gaps between
    task automatic send_word(input logic [9:0] s, input logic [1:0] p,
                             input bit lit_on, input ocd_pkg::t_result lit);
        if (burst_left == 0) begin
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                : $urandom_range(1, 4)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        i_in_valid   <= 1'b1;
        i_sample     <= s;
        i_raw_inputs <= p;
        word_lit_on  <= lit_on;
        word_lit     <= lit;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        if (burst_left == 0)
            i_in_valid <= 1'b0;
    endtask

    // One averaging group; only the closing word's pins reach the debouncer
    task automatic send_group(input int level, input int spread, input logic [1:0] pins,
                              input bit lit_on, input ocd_pkg::t_result lit);
        int         v;
        logic [1:0] p;
        for (int i = 0; i < SAMPLES_PER_AVG; i++) begin
            v = level;
            if (spread > 0)
                v = v + int'($urandom_range(0, 2 * spread)) - spread;
            p = (i == SAMPLES_PER_AVG - 1) ? pins : 2'($urandom_range(0, 3));
            send_word(to_sample(v), p, lit_on && (i == SAMPLES_PER_AVG - 1), lit);
        end
        groups_sent++;
    endtask

    task automatic stop_sending();
        if (burst_left != 0) begin
            i_in_valid <= 1'b0;
            burst_left = 0;
        end
    endtask

    // Wait for every awaited word, then let the pipeline settle
    task automatic wait_idle();
        @(posedge i_clk);
        while (pending_status.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [ocd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [ocd_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic plan_group(input int level, input int spread, input logic [1:0] pins,
                              input bit lit_on = 1'b0, input ocd_pkg::t_result lit = '0);
        plan.push_back('{kind: ROW_GROUP, level: level, spread: spread, pins: pins,
                         lit_on: lit_on, lit: lit, reg_idx: '0, reg_data: '0});
    endtask

    task automatic plan_write(input logic [ocd_pkg::CFG_INDEX_W-1:0] idx,
                              input logic [ocd_pkg::CFG_DATA_W-1:0] data);
        plan.push_back('{kind: ROW_WRITE, level: 0, spread: 0, pins: '0,
                         lit_on: 1'b0, lit: '0, reg_idx: idx, reg_data: data});
    endtask

    initial begin
        t_plan_row row;
        t_scenario kind;
        int        n;
        int        lvl;
        int        margin;
        int        run;
        int        base;
        int        hold_n;
        int        random_target;
        bit        above;
        bit        aux;
        bit        full;

        // Directed plan; typed words are {occupied, detected, calibrating, threshold, average}
        plan_group(0, 0, 2'b00, 1'b1, {1'b0, 1'b0, 1'b0, 10'd29, 10'd0});
        plan_group(0, 0, 2'b01, 1'b1, {1'b0, 1'b0, 1'b0, 10'd29, 10'd0});
        plan_group(0, 0, 2'b01, 1'b1, {1'b0, 1'b0, 1'b0, 10'd29, 10'd0});
        plan_group(0, 0, 2'b01, 1'b1, {1'b0, 1'b0, 1'b0, 10'd29, 10'd0});
        // fourth aux read settles the pin
        plan_group(0, 0, 2'b01, 1'b1, {1'b1, 1'b0, 1'b0, 10'd29, 10'd0});
        // full scale until the on delay runs out, aux dropping meanwhile
        repeat (6) plan_group(1023, 0, 2'b00);
        plan_group(0, 0, 2'b00);
        plan_group(0, 0, 2'b00);
        plan_group(512, 511, 2'b00);
        // threshold at the top, where clear hysteresis cannot be added
        plan_write(ocd_pkg::REG_START_THRESHOLD, 10'd1023);
        plan_write(ocd_pkg::REG_ON_DELAY, 10'd1);
        plan_write(ocd_pkg::REG_OFF_DELAY, 10'd1);
        plan_write(REG_UNUSED, 10'h2AA);
        plan_group(1023, 0, 2'b00);
        plan_group(1018, 0, 2'b00);
        plan_group(1018, 0, 2'b00);
        plan_group(1023, 0, 2'b00);
        plan_group(1023, 0, 2'b00);
        // erased register values, then a threshold too low to lower
        plan_write(ocd_pkg::REG_START_THRESHOLD, 10'd0);
        plan_write(ocd_pkg::REG_ON_DELAY, 10'h3FF);
        plan_write(ocd_pkg::REG_OFF_DELAY, 10'd0);
        plan_write(ocd_pkg::REG_START_THRESHOLD, 10'd3);
        plan_write(ocd_pkg::REG_OFF_DELAY, 10'd254);
        plan_write(ocd_pkg::REG_ON_DELAY, 10'd1);
        plan_group(0, 0, 2'b00);
        plan_group(10, 0, 2'b00);
        plan_group(10, 0, 2'b00);
        plan_group(3, 0, 2'b00);
        plan_group(4, 0, 2'b00);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed plan
        foreach (plan[r]) begin
            row = plan[r];
            if (row.kind == ROW_WRITE) begin
                stop_sending();
                wait_idle();
                cfg_write(row.reg_idx, row.reg_data);
            end else begin
                send_group(row.level, row.spread, row.pins, row.lit_on, row.lit);
            end
        end

        // Random scenarios, each behind a fresh set of registers
        random_target = groups_sent + RANDOM_GROUPS;
        for (int sc = 0; groups_sent < random_target; sc++) begin
            stop_sending();
            wait_idle();
            case ($urandom_range(0, 9))
                0:       cfg_write(ocd_pkg::REG_START_THRESHOLD, 10'd0);
                1:       cfg_write(ocd_pkg::REG_START_THRESHOLD, 10'd1);
                2:       cfg_write(ocd_pkg::REG_START_THRESHOLD, 10'd1023);
                default: cfg_write(ocd_pkg::REG_START_THRESHOLD,
                                   10'($urandom_range(1, 1023)));
            endcase
            cfg_write(ocd_pkg::REG_ON_DELAY, ($urandom_range(0, 9) < 7)
                ? 10'($urandom_range(1, 6) | ($urandom_range(0, 3) << 8))
                : 10'($urandom_range(0, 1023)));
            cfg_write(ocd_pkg::REG_OFF_DELAY, ($urandom_range(0, 9) < 7)
                ? 10'($urandom_range(1, 8) | ($urandom_range(0, 3) << 8))
                : 10'($urandom_range(0, 1023)));

            kind = (sc == 0 || sc == 3) ? SCN_CALIBRATE : t_scenario'($urandom_range(0, 2));
            case (kind)
                SCN_CALIBRATE: begin
                    // hold the button, release it, then after a full hold feed the collected averages
                    aux    = $urandom_range(0, 1);
                    full   = ($urandom_range(0, 3) != 0);
                    hold_n = full ? $urandom_range(24, 27) : $urandom_range(5, 23);
                    repeat (hold_n)
                        send_group(int'(thr_now) + int'($urandom_range(0, 60)) - 30, 4,
                                   {1'b1, aux}, 1'b0, '0);
                    repeat (4)
                        send_group(int'(thr_now) + int'($urandom_range(0, 60)) - 30, 4,
                                   {1'b0, aux}, 1'b0, '0);
                    if (full) begin
                        case ($urandom_range(0, 2))
                            0:       base = $urandom_range(0, 8);
                            1:       base = $urandom_range(9, 79);
                            default: base = $urandom_range(80, 1015);
                        endcase
                        repeat (CAL_AVERAGES + 1)
                            send_group(base + int'($urandom_range(0, 3)), $urandom_range(0, 1),
                                       2'($urandom_range(0, 3)), 1'b0, '0);
                        repeat (3)
                            send_group($urandom_range(0, 1023), 8, {1'b0, aux}, 1'b0, '0);
                    end
                end
                SCN_DETECT: begin
                    // runs above and below the threshold, some right at the hysteresis edge
                    n     = $urandom_range(8, 20);
                    above = $urandom_range(0, 1);
                    aux   = 1'b0;
                    run   = 0;
                    repeat (n) begin
                        if (run == 0) begin
                            above = !above;
                            run   = $urandom_range(1, 8);
                            aux   = $urandom_range(0, 1);
                        end
                        run--;
                        if ($urandom_range(0, 3) == 0) begin
                            margin = $urandom_range(4, 6);
                            lvl    = above ? int'(thr_now) + margin : int'(thr_now) - margin;
                            send_group(lvl, 0, {1'b0, aux}, 1'b0, '0);
                        end else begin
                            margin = $urandom_range(7, 40);
                            lvl    = above ? int'(thr_now) + margin : int'(thr_now) - margin;
                            send_group(lvl, $urandom_range(0, 2), {1'b0, aux}, 1'b0, '0);
                        end
                    end
                end
                default: begin
                    // random levels and pins that glitch the debouncer
                    n = $urandom_range(4, 12);
                    repeat (n)
                        send_group($urandom_range(0, 1023), $urandom_range(0, 511),
                                   2'($urandom_range(0, 3)), 1'b0, '0);
                end
            endcase
        end

        stop_sending();
        wait_idle();
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
